@@ rtl/core/tpil_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpil_pkg
// shared types and constants of the track position interval locator
// ---------------------------------------------------------------------------
package tpil_pkg;

   localparam int MAX_POINTS = 256;
   localparam int ADDR_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int COUNT_W    = $clog2(MAX_POINTS + 1);

   localparam int KM_W   = 16;
   localparam int M_W    = 12;
   localparam int CODE_W = 20;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_QUERY  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      CLS_UNDEFINED  = 2'd0,
      CLS_ON_STATION = 2'd1,
      CLS_BETWEEN    = 2'd2
   } loc_class_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PACK
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [KM_W-1:0]   km;
      logic [M_W-1:0]    m;
   } point_type;

   typedef struct packed {
      logic          prev_valid;
      logic          next_valid;
      loc_class_type loc_class;
      point_type     prev;
      point_type     next;
   } result_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic append;
      logic load_query;
      logic scan;
      logic pack;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic rsp_busy;
   } status_type;

endpackage
`default_nettype wire

@@ rtl/core/tpil_ctrl.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpil_ctrl
// sequencer: decodes input beats, runs the table scan, hands off the result
// ---------------------------------------------------------------------------
module tpil_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_action,
   output tpil_pkg::cmd_type          cmd,
   input  wire tpil_pkg::status_type  status,
   output tpil_pkg::state_type        state
);
   import tpil_pkg::*;

   state_type state_ff;
   state_type state_in;
   action_type action;

   assign action = action_type'(req_action);
   assign state  = state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (action)
                  ACT_CLEAR:  cmd.clear = 1'b1;
                  ACT_APPEND: cmd.append = 1'b1;
                  ACT_QUERY: begin
                     cmd.load_query = 1'b1;
                     state_in       = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            // wait for the output register to free up
            if (!status.rsp_busy) begin
               cmd.pack = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/core/tpil_dpath.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tpil_dpath
// point table memory, entry count, scan pointer, compare and result register
// ---------------------------------------------------------------------------
module tpil_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tpil_pkg::cmd_type           cmd,
   output tpil_pkg::status_type             status,
   input  wire logic [tpil_pkg::KM_W-1:0]   req_km,
   input  wire logic [tpil_pkg::M_W-1:0]    req_m,
   input  wire logic [tpil_pkg::CODE_W-1:0] req_code,
   input  wire logic                        rsp_tready,
   output logic                             rsp_valid,
   output tpil_pkg::result_type             rsp_result
);
   import tpil_pkg::*;

   point_type point_mem [MAX_POINTS];

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [KM_W-1:0]    q_km_ff, q_km_in;
   logic [M_W-1:0]     q_m_ff, q_m_in;
   logic               rd_live_ff, rd_live_in;
   point_type          rd_data_ff;
   point_type          prev_ff, prev_in;
   point_type          next_ff, next_in;
   logic               pv_ff, pv_in;
   logic               nv_ff, nv_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               issue;
   logic               hit_le;
   logic               not_full;
   loc_class_type      cls;

   assign not_full = (count_ff < COUNT_W'(MAX_POINTS));
   assign issue    = cmd.scan && (idx_ff < count_ff);
   assign hit_le   = ({rd_data_ff.km, rd_data_ff.m} <= {q_km_ff, q_m_ff});

   assign status.scan_done = (rd_live_ff && !hit_le) || (!rd_live_ff && (idx_ff == count_ff));
   assign status.rsp_busy  = rsp_valid_ff && !rsp_tready;

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append && not_full) begin
         point_mem[count_ff[ADDR_W-1:0]] <= '{code: req_code, km: req_km, m: req_m};
      end
      if (issue) begin
         rd_data_ff <= point_mem[idx_ff[ADDR_W-1:0]];
      end
   end

   always_comb begin
      if (!pv_ff && !nv_ff) begin
         cls = CLS_UNDEFINED;
      end else if (pv_ff && nv_ff && (prev_ff.code == next_ff.code)) begin
         cls = CLS_ON_STATION;
      end else begin
         cls = CLS_BETWEEN;
      end
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      q_km_in      = q_km_ff;
      q_m_in       = q_m_ff;
      rd_live_in   = rd_live_ff;
      prev_in      = prev_ff;
      next_in      = next_ff;
      pv_in        = pv_ff;
      nv_in        = nv_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.append && not_full) begin
         count_in = count_ff + COUNT_W'(1);
      end

      if (cmd.load_query) begin
         q_km_in    = req_km;
         q_m_in     = req_m;
         idx_in     = '0;
         rd_live_in = 1'b0;
         prev_in    = '0;
         next_in    = '0;
         pv_in      = 1'b0;
         nv_in      = 1'b0;
      end

      if (cmd.scan) begin
         rd_live_in = issue;
         if (issue) begin
            idx_in = idx_ff + COUNT_W'(1);
         end
         if (rd_live_ff) begin
            if (hit_le) begin
               prev_in = rd_data_ff;
               pv_in   = 1'b1;
            end else begin
               next_in = rd_data_ff;
               nv_in   = 1'b1;
            end
         end
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.pack) begin
         rsp_valid_in      = 1'b1;
         rsp_in.prev_valid = pv_ff;
         rsp_in.next_valid = nv_ff;
         rsp_in.loc_class  = cls;
         rsp_in.prev       = prev_ff;
         rsp_in.next       = next_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_live_ff   <= 1'b0;
         pv_ff        <= 1'b0;
         nv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_live_ff   <= rd_live_in;
         pv_ff        <= pv_in;
         nv_ff        <= nv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_km_ff <= q_km_in;
      q_m_ff  <= q_m_in;
      prev_ff <= prev_in;
      next_ff <= next_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/core/track_position_interval_locator_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// track_position_interval_locator_core
// boundary point table with bracketing interval search
// ---------------------------------------------------------------------------
// The block holds up to MAX_POINTS (256) boundary points, each a station code
// with a kilometre/metre position. The user must append them in ascending
// order; the block itself does not enforce it. Each request beat carries
// an action in req_tuser: clear empties the table, append adds a point
// (dropped silently once the table is full), query scans the table from
// the first entry and returns one response beat with the last point at or
// before the position, the first point after it and a location class
// (undefined, on station, between stations). Clear and append are done on
// their accepting beat. A query holds the request channel from its
// accepting beat through the scan and the hand-off: the scan passes the
// entries at or before the position and stops at the first point past the
// position or at the end of the table. The single read port of the point
// table delivers one entry per cycle to the compare, each compare in the
// cycle after its read. The hand-off waits as long as the previous
// response beat is unclaimed. One request is in flight at a time, but a
// finished response waits in its own output register, so clears and
// appends are taken while it is still unclaimed.
// The table needs no clearing pass after reset; only written entries are read.
// ---------------------------------------------------------------------------
module track_position_interval_locator_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [15:0] pos_km, [27:16] pos_m, [47:28] station_code
   input  wire logic [47:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [19:0] prev_code, [35:20] prev_km, [47:36] prev_m,
   // [67:48] next_code, [83:68] next_km, [95:84] next_m
   output logic [95:0]      rsp_tdata,
   // [0] prev_valid, [1] next_valid, [3:2] location_class
   output logic [3:0]       rsp_tuser
);
   import tpil_pkg::*;

   cmd_type    cmd;
   status_type status;
   state_type  state;
   result_type result;

   logic [KM_W-1:0]   req_km;
   logic [M_W-1:0]    req_m;
   logic [CODE_W-1:0] req_code;

   // unpack the request beat
   assign req_km   = req_tdata[15:0];
   assign req_m    = req_tdata[27:16];
   assign req_code = req_tdata[47:28];

   tpil_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .state      (state)
   );

   tpil_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_km     (req_km),
      .req_m      (req_m),
      .req_code   (req_code),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_result (result)
   );

   // pack the response beat
   assign rsp_tdata = {result.next.m, result.next.km, result.next.code,
                       result.prev.m, result.prev.km, result.prev.code};
   assign rsp_tuser = {result.loc_class, result.next_valid, result.prev_valid};

   // a query beat moves the sequencer into the scan
   a_query_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == ACT_QUERY)) |=> (state == ST_SCAN))
      else $error("query beat did not start a scan");

   // no new request is taken while a scan or hand-off is pending
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ((state == ST_SCAN) || (state == ST_PACK)) |-> !req_tready)
      else $error("request accepted while a query is in progress");

   // class agrees with the valid flags of the response
   a_class_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser[3:2] == CLS_UNDEFINED) == (!rsp_tuser[0] && !rsp_tuser[1])))
      else $error("location class inconsistent with valid flags");

   // a missing preceding point reads as zeros
   a_prev_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[47:0] == '0))
      else $error("preceding point fields not zero when invalid");

endmodule
`default_nettype wire
